@@ design/rplm_pkg.sv @@
package rplm_pkg;

  localparam int SMP_W          = 16;
  localparam int MAG_W          = 16;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int MEAN_W         = 32;
  localparam int RMS_W          = 16;
  localparam int PEAK_W         = 15;
  localparam int OUT_DATA_W     = 32;
  localparam int MAX_WINDOW_DEF = 16384;
  localparam int SUM_W_DEF      = SQ_W - 1 + $clog2(MAX_WINDOW_DEF) + 1;
  localparam int DEN_W_DEF      = $clog2(MAX_WINDOW_DEF + 1);

  localparam logic [RMS_W-1:0] FULL_SCALE = RMS_W'(32768);

endpackage

@@ design/rms_peak_level_meter_unit.sv @@
// Windowed RMS and peak level meter.
// Input stream: one signed 16-bit PCM sample per word on in_tdata, in_tlast
// marks the last sample of a level window. Result stream: one word per
// window, carrying the RMS level and the peak level (units of 1/32768, so
// 32768 is full scale) and, on out_tuser, a flag for samples dropped because
// the window already held MAX_WINDOW samples.
// Each sample is squared by a bit-serial shift-add multiplier, one bit a
// cycle, so a sample that does not end a window holds in_tready low until
// its square has been added to the window sum. A sample beyond MAX_WINDOW
// is dropped without being squared.
// At a window end the mean is found by a restoring divider over the SUM_W-bit
// window sum (46 bits at the default MAX_WINDOW) and the root by a
// two-bit-per-cycle square root.
// The result sits in an output register; the next window is accepted while
// it waits. If the receiver still stalls when the next result is ready the
// block holds it and keeps in_tready low until out_tready frees the register.
// A synchronous reset clears the window state and empties the output.
module rms_peak_level_meter_unit #(
  parameter int MAX_WINDOW = rplm_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rplm_pkg::SMP_W-1:0]      in_tdata,   // [15:0] sample
  input  logic                            in_tlast,   // window_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rplm_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] rms_level, [30:16] peak_level
  output logic                            out_tuser   // window_overflowed
);
  import rplm_pkg::*;

  localparam int SUM_W = SQ_W - 1 + $clog2(MAX_WINDOW) + 1;
  localparam int DEN_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQR  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [PEAK_W-1:0]  peak_r, peak_nxt;
  logic [DEN_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic [RMS_W-1:0]   rms_r, rms_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RMS_W-1:0]   out_rms_r;
  logic [PEAK_W-1:0]  out_peak_r;
  logic               out_ovf_r;
  logic               load_out;

  logic               in_acc;
  logic               full;
  logic [MAG_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_add;
  logic               sq_start, sq_done;
  logic [SQ_W-1:0]    sq_res;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_num;
  logic [MEAN_W-1:0]  mean;
  logic               rt_start, rt_done;
  logic [RMS_W-1:0]   root;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r == DEN_W'(MAX_WINDOW));
  assign mag       = in_tdata[SMP_W-1] ? (~in_tdata + SMP_W'(1)) : in_tdata;
  assign sum_add   = sum_r + SUM_W'(sq_res);
  assign div_num   = (state_r == S_SQR) ? sum_add : sum_r;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    rms_nxt       = rms_r;
    out_valid_nxt = out_valid_r && !out_tready;
    load_out      = 1'b0;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    rt_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_tlast;
          if (full) begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              if (cnt_r != '0) begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end else begin
                rms_nxt   = '0;
                state_nxt = S_OUT;
              end
            end
          end else begin
            sq_start = 1'b1;
            cnt_nxt  = cnt_r + DEN_W'(1);
            if (!in_tdata[SMP_W-1] && (in_tdata[PEAK_W-1:0] > peak_r)) begin
              peak_nxt = in_tdata[PEAK_W-1:0];
            end
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (sq_done) begin
          sum_nxt = sum_add;
          if (last_r) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rt_start  = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (rt_done) begin
          rms_nxt   = (root > FULL_SCALE) ? FULL_SCALE : root;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          peak_nxt      = '0;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      peak_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rms_r <= rms_nxt;
    if (load_out) begin
      out_rms_r  <= rms_r;
      out_peak_r <= peak_r;
      out_ovf_r  <= ovf_r;
    end
  end

  rplm_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .mag    (mag),
    .done   (sq_done),
    .square (sq_res)
  );

  rplm_div #(
    .SUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (mean)
  );

  rplm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (mean),
    .done     (rt_done),
    .root     (root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RMS_W - PEAK_W){1'b0}}, out_peak_r, out_rms_r};
  assign out_tuser  = out_ovf_r;

endmodule

@@ design/rplm_square.sv @@
module rplm_square (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rplm_pkg::MAG_W-1:0] mag,
  output logic                       done,
  output logic [rplm_pkg::SQ_W-1:0]  square
);
  import rplm_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);

  logic [SQ_W-1:0]   prod_r, prod_nxt;
  logic [MAG_W-1:0]  mcand_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [MAG_W:0]    part_sum;

  // shift-add, one multiplier bit a cycle
  always_comb begin
    part_sum = {1'b0, prod_r[SQ_W-1:MAG_W]};
    if (prod_r[0]) begin
      part_sum = part_sum + {1'b0, mcand_r};
    end
    prod_nxt = {part_sum, prod_r[MAG_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{MAG_W{1'b0}}, mag};
      mcand_r <= mag;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign done   = done_r;
  assign square = prod_r;

endmodule

@@ design/rplm_div.sv @@
module rplm_div #(
  parameter int SUM_W = rplm_pkg::SUM_W_DEF,
  parameter int DEN_W = rplm_pkg::DEN_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [SUM_W-1:0]            dividend,
  input  logic [DEN_W-1:0]            divisor,
  output logic                        done,
  output logic [rplm_pkg::MEAN_W-1:0] quotient
);
  import rplm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = MEAN_W'(quo_r);

endmodule

@@ design/rplm_sqrt.sv @@
module rplm_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rplm_pkg::MEAN_W-1:0] radicand,
  output logic                        done,
  output logic [rplm_pkg::RMS_W-1:0]  root
);
  import rplm_pkg::*;

  localparam int RT_W   = MEAN_W / 2;
  localparam int REM_W  = RT_W + 3;
  localparam int STEP_W = $clog2(RT_W);

  logic [MEAN_W-1:0] rad_r;
  logic [RT_W-1:0]   root_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // digit-by-digit root, two radicand bits a cycle
  always_comb begin
    shifted = {rem_r[REM_W-3:0], rad_r[MEAN_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    fits    = shifted >= trial;
    rem_nxt = fits ? (shifted - trial) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(RT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[MEAN_W-3:0], 2'b00};
      root_r <= {root_r[RT_W-2:0], fits};
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign root = RMS_W'(root_r);

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rplm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int SUM_BITS       = 47;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic [PEAK_W-1:0] peak;
    logic              dropped;
  } level_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SMP_W-1:0]      in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // window state of the level predictor
  logic [SUM_BITS-1:0] sq_sum       = '0;
  logic [PEAK_W-1:0]   peak_hold    = '0;
  int                  kept_count   = 0;
  logic                dropped_flag = 1'b0;

  level_t expected_levels[$];
  int     mismatches  = 0;
  int     idle_cycles = 0;
  bit     idle_en     = 1'b1;
  bit     out_block   = 1'b0;

  rms_peak_level_meter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) begin
        root = cand;
      end
    end
    return root;
  endfunction

  task automatic update_levels(input logic [SMP_W-1:0] smp, input bit last);
    int              value;
    level_t          lvl;
    longint unsigned mean;
    longint unsigned root;
    value = int'($signed(smp));
    if (kept_count >= MAX_WINDOW_DEF) begin
      dropped_flag = 1'b1;
    end else begin
      sq_sum = sq_sum + SUM_BITS'(value * value);
      if (value > int'(peak_hold)) begin
        peak_hold = PEAK_W'(value);
      end
      kept_count++;
    end
    if (last) begin
      lvl.rms = '0;
      if (kept_count != 0) begin
        mean = 64'(sq_sum) / 64'(kept_count);
        root = floor_sqrt(mean);
        lvl.rms = (root > FULL_SCALE) ? FULL_SCALE : RMS_W'(root);
      end
      lvl.peak    = peak_hold;
      lvl.dropped = dropped_flag;
      expected_levels.push_back(lvl);
      sq_sum       = '0;
      peak_hold    = '0;
      kept_count   = 0;
      dropped_flag = 1'b0;
    end
  endtask

  task automatic send_sample(input logic [SMP_W-1:0] smp, input bit last);
    while (idle_en && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    update_levels(smp, last);
  endtask

  function automatic logic [SMP_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return ($urandom_range(1) == 0) ? 16'h0000 : 16'hffff;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int exp_val, input int act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    level_t exp_lvl;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_levels.size() == 0) begin
        note_mismatch("unexpected result word", 0, 1);
      end else begin
        exp_lvl = expected_levels.pop_front();
        if (out_tdata[15:0] !== exp_lvl.rms) begin
          note_mismatch("rms_level", exp_lvl.rms, out_tdata[15:0]);
        end
        if (out_tdata[30:16] !== exp_lvl.peak) begin
          note_mismatch("peak_level", exp_lvl.peak, out_tdata[30:16]);
        end
        if (out_tuser !== exp_lvl.dropped) begin
          note_mismatch("window_overflowed", exp_lvl.dropped, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !out_block && !(idle_en && $urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_extremes();
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'haaaa, 1'b1);
    // negative only window keeps the peak at zero
    send_sample(16'hc000, 1'b0);
    send_sample(16'hfffe, 1'b1);
    send_sample(16'h0003, 1'b0);
    send_sample(16'h0004, 1'b1);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  task automatic test_result_backpressure();
    out_block = 1'b1;
    fork
      begin
        send_sample(16'h1234, 1'b1);
        send_sample(16'hf000, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h7ffe, 1'b1);
      end
    join_none
    wait (expected_levels.size() >= 2);
    repeat (200) @(posedge clk);
    out_block = 1'b0;
    wait fork;
  endtask

  task automatic test_sender_pause();
    for (int w = 0; w < 3; w++) begin
      send_sample(random_sample(), 1'b0);
      send_sample(random_sample(), 1'b1);
    end
    in_tvalid <= 1'b0;
    wait (expected_levels.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_random_windows();
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = !(sent >= 600 && sent < 1000);
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(16, 1);
      end else if (pick < 90) begin
        len = $urandom_range(64, 17);
      end else begin
        len = $urandom_range(300, 65);
      end
      for (int i = 0; i < len; i++) begin
        send_sample(random_sample(), i == len - 1);
      end
      sent += len;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_result_backpressure();
    test_sender_pause();
    test_random_windows();
    in_tvalid <= 1'b0;
    wait (expected_levels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rplm_pkg.sv
design/rplm_square.sv
design/rplm_div.sv
design/rplm_sqrt.sv
design/rms_peak_level_meter_unit.sv
tb/sv/testbench.sv
